// File: rtl/pip_hd_pkg.sv
// Package for the point-in-polygon height difference block.
// Holds the token that travels the edge cell chain, the codes and the edge math.
// Depends on nothing; every other file of the block uses it.
`default_nettype none

package pip_hd_pkg;

	localparam int unsigned MAX_VERTICES = 64;
	localparam int unsigned IDX_W        = $clog2(MAX_VERTICES);
	// Edges from an accepting edge to the edge that takes the result.
	localparam int unsigned RESULT_LAT   = MAX_VERTICES + 3;

	localparam logic [30:0] Z_LIMIT_RESET = 31'd26;

	localparam logic KIND_LOAD  = 1'b0;
	localparam logic KIND_QUERY = 1'b1;

	localparam logic [1:0] REG_VERTEX_COUNT = 2'd0;
	localparam logic [1:0] REG_Z_LIMIT      = 2'd1;

	typedef logic [IDX_W-1:0] vidx_t;

	// One item on its way through the chain, with the crossing state so far.
	typedef struct packed {
		logic               kind;
		logic [5:0]         vertex_index;
		logic signed [31:0] x;
		logic signed [31:0] y;
		logic signed [32:0] zdiff;
		logic               odd;
		logic               have_prev;
		logic signed [31:0] prev_x;
		logic signed [31:0] prev_y;
		logic signed [31:0] first_x;
		logic signed [31:0] first_y;
		logic               pend;
		logic signed [65:0] lhs;
		logic signed [65:0] rhs;
	} tok_t;

	typedef struct packed {
		logic               straddle;
		logic signed [65:0] lhs;
		logic signed [65:0] rhs;
	} cross_t;

	// Crossing terms for the edge from vertex i to vertex j against point p.
	// The point crosses when straddle is set and lhs <= rhs.
	function automatic cross_t edge_terms(
		input logic signed [31:0] xi,
		input logic signed [31:0] yi,
		input logic signed [31:0] xj,
		input logic signed [31:0] yj,
		input logic signed [31:0] px,
		input logic signed [31:0] py
	);
		cross_t             r;
		logic signed [32:0] dye;
		logic signed [32:0] ady;
		logic signed [32:0] dx;
		logic signed [32:0] sdx;
		logic signed [32:0] dpx;
		logic signed [32:0] dpy;
		dye = $signed({yj[31], yj}) - $signed({yi[31], yi});
		dx  = $signed({xj[31], xj}) - $signed({xi[31], xi});
		dpx = $signed({px[31], px}) - $signed({xi[31], xi});
		dpy = $signed({py[31], py}) - $signed({yi[31], yi});
		// Both sides are scaled by |dye|, so the edge direction moves into dx.
		ady = dye[32] ? -dye : dye;
		sdx = dye[32] ? -dx : dx;
		r.straddle = (yi >= py) != (yj >= py);
		r.lhs      = $signed(66'(dpx)) * $signed(66'(ady));
		r.rhs      = $signed(66'(sdx)) * $signed(66'(dpy));
		return r;
	endfunction

endpackage

`default_nettype wire

// File: rtl/point_in_polygon_height_diff.sv
// Point-in-polygon crossing test with height comparison, top level.
// Every item, load or query, enters a register and walks a chain of MAX_VERTICES
// edge cells and a two-stage tail, whose second stage drives done.
// One item per clock: busy stays low.
// Reset clears the chain's valid bits and the registers (vertex_count 0,
// z_limit 26); the stored vertices are kept. The receiver cannot stall.
`default_nettype none

module point_in_polygon_height_diff (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	output logic                    busy,
	input  wire logic               kind,
	input  wire logic [5:0]         vertex_index,
	input  wire logic signed [31:0] coord_x,
	input  wire logic signed [31:0] coord_y,
	input  wire logic signed [31:0] query_z,
	input  wire logic signed [31:0] ref_z,
	input  wire logic               cfg_valid,
	output logic                    cfg_ready,
	input  wire logic [1:0]         cfg_index,
	input  wire logic [30:0]        cfg_data,
	output logic                    done,
	output logic                    inside_res,
	output logic                    differs
);

	logic [6:0]       vertex_count_q;
	logic [30:0]      z_limit_q;
	logic             entry_valid_q;
	pip_hd_pkg::tok_t entry_tok_q;
	logic             chain_valid [0:pip_hd_pkg::MAX_VERTICES];
	pip_hd_pkg::tok_t chain_tok   [0:pip_hd_pkg::MAX_VERTICES];

	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vertex_count_q <= 7'd0;
			z_limit_q      <= pip_hd_pkg::Z_LIMIT_RESET;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				pip_hd_pkg::REG_VERTEX_COUNT: vertex_count_q <= cfg_data[6:0];
				pip_hd_pkg::REG_Z_LIMIT:      z_limit_q      <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_valid_q <= 1'b0;
		end else begin
			entry_valid_q <= start;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			entry_tok_q.kind         <= kind;
			entry_tok_q.vertex_index <= vertex_index;
			entry_tok_q.x            <= coord_x;
			entry_tok_q.y            <= coord_y;
			entry_tok_q.zdiff        <= $signed({query_z[31], query_z}) -
			                            $signed({ref_z[31], ref_z});
			entry_tok_q.odd          <= 1'b0;
			entry_tok_q.have_prev    <= 1'b0;
			entry_tok_q.prev_x       <= coord_x;
			entry_tok_q.prev_y       <= coord_y;
			entry_tok_q.first_x      <= coord_x;
			entry_tok_q.first_y      <= coord_y;
			entry_tok_q.pend         <= 1'b0;
			entry_tok_q.lhs          <= '0;
			entry_tok_q.rhs          <= '0;
		end
	end

	assign chain_valid[0] = entry_valid_q;
	assign chain_tok[0]   = entry_tok_q;

	for (genvar g = 0; g < pip_hd_pkg::MAX_VERTICES; g++) begin : g_cell
		pip_hd_cell u_cell (
			.clk          (clk),
			.arst_n       (arst_n),
			.cell_idx     (pip_hd_pkg::vidx_t'(g)),
			.vertex_count (vertex_count_q),
			.in_valid     (chain_valid[g]),
			.in_tok       (chain_tok[g]),
			.out_valid    (chain_valid[g+1]),
			.out_tok      (chain_tok[g+1])
		);
	end

	pip_hd_tail u_tail (
		.clk        (clk),
		.arst_n     (arst_n),
		.z_limit    (z_limit_q),
		.in_valid   (chain_valid[pip_hd_pkg::MAX_VERTICES]),
		.in_tok     (chain_tok[pip_hd_pkg::MAX_VERTICES]),
		.done       (done),
		.inside_res (inside_res),
		.differs    (differs)
	);

endmodule

`default_nettype wire

// File: rtl/pip_hd_cell.sv
// One edge cell of the chain: stores one polygon vertex and tests one edge.
// Uses pip_hd_pkg for the token type, the codes and the edge function.
`default_nettype none

module pip_hd_cell (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire pip_hd_pkg::vidx_t cell_idx,
	input  wire logic [6:0]        vertex_count,
	input  wire logic              in_valid,
	input  wire pip_hd_pkg::tok_t  in_tok,
	output logic                   out_valid,
	output pip_hd_pkg::tok_t       out_tok
);

	logic signed [31:0] vx_q;
	logic signed [31:0] vy_q;
	logic               out_valid_q;
	pip_hd_pkg::tok_t   out_tok_q;
	pip_hd_pkg::tok_t   nxt_tok;
	pip_hd_pkg::cross_t terms;
	logic               active;
	logic               load_hit;

	assign load_hit = in_valid && (in_tok.kind == pip_hd_pkg::KIND_LOAD) &&
	                  (32'(in_tok.vertex_index) == 32'(cell_idx));
	// A count above the chain length leaves every cell active.
	assign active   = (in_tok.kind == pip_hd_pkg::KIND_QUERY) &&
	                  (32'(vertex_count) > 32'(cell_idx));

	assign terms = pip_hd_pkg::edge_terms(vx_q, vy_q, in_tok.prev_x, in_tok.prev_y,
	                                      in_tok.x, in_tok.y);

	always_comb begin
		nxt_tok      = in_tok;
		// Settle the edge that the previous cell multiplied out.
		nxt_tok.odd  = in_tok.odd ^ (in_tok.pend && (in_tok.lhs <= in_tok.rhs));
		nxt_tok.pend = 1'b0;
		if (active) begin
			if (in_tok.have_prev) begin
				nxt_tok.pend = terms.straddle;
				nxt_tok.lhs  = terms.lhs;
				nxt_tok.rhs  = terms.rhs;
			end else begin
				nxt_tok.first_x   = vx_q;
				nxt_tok.first_y   = vy_q;
				nxt_tok.have_prev = 1'b1;
			end
			nxt_tok.prev_x = vx_q;
			nxt_tok.prev_y = vy_q;
		end
	end

	always_ff @(posedge clk) begin
		if (load_hit) begin
			vx_q <= in_tok.x;
			vy_q <= in_tok.y;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else begin
			out_valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		out_tok_q <= nxt_tok;
	end

	assign out_valid = out_valid_q;
	assign out_tok   = out_tok_q;

endmodule

`default_nettype wire

// File: rtl/pip_hd_tail.sv
// Tail of the chain: tests the closing edge and forms the result beat.
// Uses pip_hd_pkg for the token type, the codes and the edge function.
`default_nettype none

module pip_hd_tail (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic [30:0]      z_limit,
	input  wire logic             in_valid,
	input  wire pip_hd_pkg::tok_t in_tok,
	output logic                  done,
	output logic                  inside_res,
	output logic                  differs
);

	pip_hd_pkg::cross_t terms;
	pip_hd_pkg::tok_t   nxt_tok;
	logic               valid_s1;
	pip_hd_pkg::tok_t   tok_s1;
	logic               inside_fin;
	logic [32:0]        zmag;
	logic               done_s2;
	logic               inside_s2;
	logic               differs_s2;

	// Closing edge runs from the first vertex back to the last one in use.
	assign terms = pip_hd_pkg::edge_terms(in_tok.first_x, in_tok.first_y,
	                                      in_tok.prev_x, in_tok.prev_y,
	                                      in_tok.x, in_tok.y);

	always_comb begin
		nxt_tok      = in_tok;
		nxt_tok.odd  = in_tok.odd ^ (in_tok.pend && (in_tok.lhs <= in_tok.rhs));
		nxt_tok.pend = 1'b0;
		if ((in_tok.kind == pip_hd_pkg::KIND_QUERY) && in_tok.have_prev) begin
			nxt_tok.pend = terms.straddle;
			nxt_tok.lhs  = terms.lhs;
			nxt_tok.rhs  = terms.rhs;
		end
	end

	assign inside_fin = (tok_s1.kind == pip_hd_pkg::KIND_QUERY) &&
	                    (tok_s1.odd ^ (tok_s1.pend && (tok_s1.lhs <= tok_s1.rhs)));
	assign zmag = tok_s1.zdiff[32] ? 33'(-tok_s1.zdiff) : 33'(tok_s1.zdiff);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			done_s2  <= 1'b0;
		end else begin
			valid_s1 <= in_valid;
			done_s2  <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		tok_s1     <= nxt_tok;
		inside_s2  <= inside_fin;
		differs_s2 <= inside_fin && (zmag >= {2'b00, z_limit});
	end

	assign done       = done_s2;
	assign inside_res = done_s2 && inside_s2;
	assign differs    = done_s2 && differs_s2;

endmodule

`default_nettype wire

// File: rtl/pip_hd_checker.sv
// Port-level checks for point_in_polygon_height_diff, bound to the top level.
// Uses pip_hd_pkg for the result latency and the item codes.
`default_nettype none

module pip_hd_checker (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	input wire logic busy,
	input wire logic kind,
	input wire logic done,
	input wire logic inside_res,
	input wire logic differs
);

	// Every accepted item yields a beat after the fixed latency.
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##(pip_hd_pkg::RESULT_LAT) done)
		else $error("accepted item produced no result beat");

	// No beat appears without an item accepted at the matching edge.
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, pip_hd_pkg::RESULT_LAT))
		else $error("result beat without an accepted item");

	// A load returns zeros.
	a_load_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && (kind == pip_hd_pkg::KIND_LOAD)) |->
		##(pip_hd_pkg::RESULT_LAT) (!inside_res && !differs))
		else $error("load beat carried a nonzero result");

	// Only an inside point can differ in height.
	a_differs_inside: assert property (@(posedge clk) disable iff (!arst_n)
		(done && differs) |-> inside_res)
		else $error("differs set for an outside point");

endmodule

bind point_in_polygon_height_diff pip_hd_checker u_pip_hd_checker (.*);

`default_nettype wire
